// ===== src/cst_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cst_pkg: shared types and constants
// Sizes, operation codes and LCG constants for the semaphore table.
// ---------------------------------------------------------------------------
package cst_pkg;
	localparam int NumSem  = 64;
	localparam int NumProc = 32;
	localparam int SemW    = $clog2(NumSem);
	localparam int PidW    = $clog2(NumProc);
	// queue link width: holds a pid or the empty marker NumProc
	localparam int LinkW   = $clog2(NumProc + 1);
	localparam int CntW    = $clog2(NumProc + 1);

	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_OPEN   = 3'd1;
	localparam logic [2:0] OP_CLOSE  = 3'd2;
	localparam logic [2:0] OP_WAIT   = 3'd3;
	localparam logic [2:0] OP_SIGNAL = 3'd4;
	localparam logic [2:0] OP_SET    = 3'd5;
	localparam logic [2:0] OP_GET    = 3'd6;
	localparam logic [2:0] OP_MODE   = 3'd7;

	localparam logic [LinkW-1:0] NO_PID  = LinkW'(NumProc);
	localparam logic [63:0] LCG_MUL  = 64'd1103515245;
	localparam logic [63:0] LCG_INC  = 64'd12345;
	localparam logic [63:0] LCG_INIT = 64'd123456789;

	typedef struct packed {
		logic        ok;
		logic        caller_blocked;
		logic [31:0] new_id;
		logic [31:0] count_read;
		logic        woken_valid;
		logic [PidW-1:0] woken_pid;
		logic        last;
	} result_t;
endpackage
`default_nettype wire

// ===== src/counting_semaphore_table_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// counting_semaphore_table_top
// Table of counting semaphores with linked per-semaphore waiter queues.
// ---------------------------------------------------------------------------
// One operation at a time. A sequencer scans the 64 slots one per cycle,
// reading each stored id through a registered port, to find the addressed id
// (or the lowest free slot). The found slot's count, references and queue
// ends are then loaded into working registers. A random pick counts the
// queue, runs the 64-bit LCG multiply as four 64x16 partial products,
// reduces modulo the waiter count by shift-subtract (one bit a cycle, 48
// steps), then walks to the chosen waiter. Each result sits in an output
// register until taken; in_stall is high while an item is in work or a
// result is waiting.
// ---------------------------------------------------------------------------
module counting_semaphore_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] sem_id,
	input  wire logic signed [31:0] operand_value,
	input  wire logic [4:0]  caller_pid,
	input  wire logic        random_enable,
	input  wire logic [63:0] entropy,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic             caller_blocked,
	output logic [31:0]      new_id,
	output logic signed [31:0] count_read,
	output logic             woken_valid,
	output logic [4:0]       woken_pid,
	output logic             last
);
	localparam int SW = cst_pkg::SemW;
	localparam int LW = cst_pkg::LinkW;
	localparam int PW = cst_pkg::PidW;
	localparam int CW = cst_pkg::CntW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_EXEC  = 4'd2;
	localparam logic [3:0] ST_TAKE  = 4'd3;
	localparam logic [3:0] ST_COUNT = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_MOD   = 4'd6;
	localparam logic [3:0] ST_WALK  = 4'd7;
	localparam logic [3:0] ST_UNL   = 4'd8;
	localparam logic [3:0] ST_DROP  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;
	localparam logic [3:0] ST_SETN  = 4'd11;
	localparam logic [3:0] ST_LOAD  = 4'd12;

	// slot state; used/mode/queued bits in flops, the rest in memories
	logic [cst_pkg::NumSem-1:0] used_q;
	logic [31:0] id_q   [cst_pkg::NumSem];
	logic [31:0] cnt_q  [cst_pkg::NumSem];
	logic [15:0] refs_q [cst_pkg::NumSem];
	logic [cst_pkg::NumSem-1:0] rmode_q;
	logic [LW-1:0] head_q [cst_pkg::NumSem];
	logic [LW-1:0] tail_q [cst_pkg::NumSem];
	logic [LW-1:0] next_q [cst_pkg::NumProc];
	logic [cst_pkg::NumProc-1:0] queued_q;
	logic [31:0] idc_q;
	logic [63:0] lcg_q;

	// item registers
	logic [3:0]  st_q;
	logic [2:0]  kind_q;
	logic [31:0] sid_q;
	logic [31:0] val_q;
	logic [PW-1:0] pid_q;
	logic        rnd_q;
	logic [63:0] ent_q;
	logic [SW:0] idx_q;
	logic [SW-1:0] slot_q;
	logic        found_q;
	logic [31:0] id_rd_q;
	logic [SW-1:0] cmp_idx_q;
	logic        cmp_v_q;
	logic [31:0] wcnt_q;
	logic [15:0] wrefs_q;
	logic [LW-1:0] whead_q, wtail_q;
	logic [LW-1:0] p_q, prev_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] target_q;
	logic [CW-1:0] woke_q;
	logic [63:0] seed_q, prod_q;
	logic [1:0]  mstep_q;
	logic [47:0] rem_num_q;
	logic [CW:0] rem_q;
	logic [5:0]  mbit_q;
	logic        setting_q;

	cst_pkg::result_t res_q;
	cst_pkg::result_t out_q;
	logic out_full_q;

	assign in_stall = (st_q != ST_IDLE) || out_full_q;
	assign out_valid = out_full_q;
	assign ok = out_q.ok;
	assign caller_blocked = out_q.caller_blocked;
	assign new_id = out_q.new_id;
	assign count_read = out_q.count_read;
	assign woken_valid = out_q.woken_valid;
	assign woken_pid = out_q.woken_pid;
	assign last = out_q.last;

	logic [SW-1:0] idx_s;
	assign idx_s = idx_q[SW-1:0];

	// shared partial product: 64-bit seed by one 16-bit slice of multiplier
	logic [15:0] mslice;
	logic [79:0] pp;
	always_comb begin
		case (mstep_q)
			2'd0: mslice = cst_pkg::LCG_MUL[15:0];
			2'd1: mslice = cst_pkg::LCG_MUL[31:16];
			2'd2: mslice = cst_pkg::LCG_MUL[47:32];
			default: mslice = cst_pkg::LCG_MUL[63:48];
		endcase
		pp = {16'd0, seed_q} * {64'd0, mslice};
	end

	logic [CW:0] rem_sh;
	assign rem_sh = {rem_q[CW-1:0], rem_num_q[47]};

	logic [LW-1:0] nxt_p;
	assign nxt_p = next_q[p_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		// result under construction
		cst_pkg::result_t r_c;
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_full_q <= 1'b0;
			used_q <= '0;
			rmode_q <= '0;
			queued_q <= '0;
			idc_q <= 32'd1;
			lcg_q <= cst_pkg::LCG_INIT;
		end else begin
			r_c = '0;
			if (out_full_q && !out_stall)
				out_full_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						kind_q <= kind;
						sid_q <= sem_id;
						val_q <= operand_value;
						pid_q <= caller_pid;
						rnd_q <= random_enable;
						ent_q <= entropy;
						idx_q <= '0;
						slot_q <= '0;
						cmp_v_q <= 1'b0;
						found_q <= 1'b0;
						woke_q <= '0;
						setting_q <= 1'b0;
						st_q <= ST_SCAN;
					end
				end
				// one slot a cycle: read its id, compare it the cycle after
				ST_SCAN: begin
					if (found_q || (idx_q[SW] && !cmp_v_q)) begin
						st_q <= ST_LOAD;
					end else begin
						cmp_v_q <= !idx_q[SW];
						if (!idx_q[SW]) begin
							id_rd_q <= id_q[idx_s];
							cmp_idx_q <= idx_s;
							idx_q <= idx_q + 1'b1;
						end
						if (cmp_v_q && (kind_q == cst_pkg::OP_ALLOC ? !used_q[cmp_idx_q]
						    : (used_q[cmp_idx_q] && id_rd_q == sid_q && sid_q != 0))) begin
							found_q <= 1'b1;
							slot_q <= cmp_idx_q;
						end
					end
				end
				// fetch the found slot into the working registers
				ST_LOAD: begin
					wcnt_q <= cnt_q[slot_q];
					wrefs_q <= refs_q[slot_q];
					whead_q <= head_q[slot_q];
					wtail_q <= tail_q[slot_q];
					st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					r_c.last = 1'b1;
					st_q <= ST_OUT;
					if (!found_q) begin
						res_q <= r_c;
					end else begin
						r_c.ok = 1'b1;
						case (kind_q)
							cst_pkg::OP_ALLOC: begin
								used_q[slot_q] <= 1'b1;
								id_q[slot_q] <= idc_q;
								cnt_q[slot_q] <= val_q;
								refs_q[slot_q] <= 16'd1;
								rmode_q[slot_q] <= 1'b0;
								head_q[slot_q] <= cst_pkg::NO_PID;
								tail_q[slot_q] <= cst_pkg::NO_PID;
								idc_q <= (idc_q == 32'hFFFF_FFFF) ? 32'd1 : idc_q + 1'b1;
								r_c.new_id = idc_q;
								res_q <= r_c;
							end
							cst_pkg::OP_OPEN: begin
								if (wrefs_q != 16'hFFFF)
									refs_q[slot_q] <= wrefs_q + 1'b1;
								res_q <= r_c;
							end
							cst_pkg::OP_CLOSE: begin
								res_q <= r_c;
								if (wrefs_q <= 16'd1) begin
									refs_q[slot_q] <= '0;
									p_q <= whead_q;
									n_q <= '0;
									st_q <= ST_DROP;
								end else begin
									refs_q[slot_q] <= wrefs_q - 1'b1;
								end
							end
							cst_pkg::OP_WAIT: begin
								if (queued_q[pid_q]) begin
									r_c.ok = 1'b0;
								end else if ($signed(wcnt_q) > 0) begin
									cnt_q[slot_q] <= wcnt_q - 1'b1;
								end else begin
									next_q[pid_q] <= cst_pkg::NO_PID;
									if (whead_q == cst_pkg::NO_PID)
										head_q[slot_q] <= LW'(pid_q);
									else
										next_q[wtail_q[PW-1:0]] <= LW'(pid_q);
									tail_q[slot_q] <= LW'(pid_q);
									queued_q[pid_q] <= 1'b1;
									r_c.caller_blocked = 1'b1;
								end
								res_q <= r_c;
							end
							cst_pkg::OP_SIGNAL: begin
								st_q <= ST_TAKE;
							end
							cst_pkg::OP_SET: begin
								if (val_q[31]) begin
									r_c.ok = 1'b0;
									res_q <= r_c;
								end else begin
									setting_q <= 1'b1;
									st_q <= ST_SETN;
								end
							end
							cst_pkg::OP_GET: begin
								r_c.count_read = wcnt_q;
								res_q <= r_c;
							end
							default: begin
								rmode_q[slot_q] <= rnd_q;
								res_q <= r_c;
							end
						endcase
					end
				end
				// set: loop over wakes while value, process limit and waiters allow
				ST_SETN: begin
					if ({{(32-CW){1'b0}}, woke_q} < val_q && 32'(woke_q) < 32'(cst_pkg::NumProc)
					    && whead_q != cst_pkg::NO_PID) begin
						st_q <= ST_TAKE;
					end else begin
						cnt_q[slot_q] <= val_q - 32'(woke_q);
						setting_q <= 1'b0;
						if (woke_q == 0) begin
							r_c.ok = 1'b1;
							r_c.last = 1'b1;
							res_q <= r_c;
							st_q <= ST_OUT;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				// start a take: empty, head, or random count
				ST_TAKE: begin
					if (whead_q == cst_pkg::NO_PID) begin
						if (!setting_q && wcnt_q != 32'h7FFF_FFFF)
							cnt_q[slot_q] <= wcnt_q + 1'b1;
						r_c.ok = 1'b1;
						r_c.last = 1'b1;
						res_q <= r_c;
						st_q <= ST_OUT;
					end else begin
						p_q <= whead_q;
						prev_q <= cst_pkg::NO_PID;
						n_q <= '0;
						target_q <= '0;
						st_q <= rmode_q[slot_q] ? ST_COUNT : ST_UNL;
					end
				end
				ST_COUNT: begin
					if (p_q == cst_pkg::NO_PID || 32'(n_q) >= 32'(cst_pkg::NumProc)) begin
						p_q <= whead_q;
						if (n_q <= 1) begin
							st_q <= ST_UNL;
						end else begin
							seed_q <= ent_q ^ 64'(slot_q) ^ lcg_q;
							prod_q <= '0;
							mstep_q <= '0;
							st_q <= ST_MUL;
						end
					end else begin
						n_q <= n_q + 1'b1;
						p_q <= nxt_p;
					end
				end
				ST_MUL: begin
					prod_q <= prod_q + (pp[63:0] << (16 * mstep_q));
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd3) begin
						st_q <= ST_MOD;
						mbit_q <= '0;
						rem_q <= '0;
					end
				end
				// restoring remainder, one bit a cycle
				ST_MOD: begin
					if (mbit_q == 6'd0) begin
						lcg_q <= prod_q + cst_pkg::LCG_INC;
						rem_num_q <= 48'((prod_q + cst_pkg::LCG_INC) >> 16);
						mbit_q <= 6'd1;
					end else if (mbit_q <= 6'd48) begin
						rem_q <= (rem_sh >= {1'b0, n_q}) ? rem_sh - {1'b0, n_q} : rem_sh;
						rem_num_q <= rem_num_q << 1;
						mbit_q <= mbit_q + 1'b1;
					end else begin
						target_q <= rem_q[CW-1:0];
						st_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (target_q == 0) begin
						st_q <= ST_UNL;
					end else begin
						prev_q <= p_q;
						p_q <= nxt_p;
						target_q <= target_q - 1'b1;
					end
				end
				// unlink p (prev is its predecessor) and report it
				ST_UNL: begin
					if (prev_q != cst_pkg::NO_PID) begin
						next_q[prev_q[PW-1:0]] <= nxt_p;
					end else begin
						head_q[slot_q] <= nxt_p;
						whead_q <= nxt_p;
					end
					if (p_q == wtail_q) begin
						tail_q[slot_q] <= prev_q;
						wtail_q <= prev_q;
					end
					queued_q[p_q[PW-1:0]] <= 1'b0;
					r_c.ok = 1'b1;
					r_c.woken_valid = 1'b1;
					r_c.woken_pid = p_q[PW-1:0];
					if (setting_q) begin
						woke_q <= woke_q + 1'b1;
						r_c.last = ({{(32-CW){1'b0}}, woke_q + 1'b1} >= val_q)
						    || (32'(woke_q) + 1 >= 32'(cst_pkg::NumProc))
						    || (prev_q == cst_pkg::NO_PID ? nxt_p == cst_pkg::NO_PID
						        : (whead_q == cst_pkg::NO_PID));
					end else begin
						r_c.last = 1'b1;
					end
					res_q <= r_c;
					st_q <= ST_OUT;
				end
				ST_DROP: begin
					if (p_q == cst_pkg::NO_PID || 32'(n_q) >= 32'(cst_pkg::NumProc)) begin
						used_q[slot_q] <= 1'b0;
						head_q[slot_q] <= cst_pkg::NO_PID;
						tail_q[slot_q] <= cst_pkg::NO_PID;
						st_q <= ST_OUT;
					end else begin
						queued_q[p_q[PW-1:0]] <= 1'b0;
						p_q <= nxt_p;
						n_q <= n_q + 1'b1;
					end
				end
				// hand the result over, then continue a set or finish
				ST_OUT: begin
					if (!out_full_q) begin
						out_q <= res_q;
						out_full_q <= 1'b1;
						st_q <= (res_q.last && !setting_q) ? ST_IDLE : ST_SETN;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/cst_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cst_port_checker
// Port-level checks for the semaphore table, bound to the top level.
// ---------------------------------------------------------------------------
module cst_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        ok,
	input wire logic        caller_blocked,
	input wire logic        woken_valid,
	input wire logic [31:0] new_id,
	input wire logic [4:0]  woken_pid,
	input wire logic        last
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(woken_pid) && $stable(last)
		&& $stable(new_id))
		else $error("result changed under stall");
	// blocked and woken never together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(caller_blocked && woken_valid))
		else $error("blocked and woken together");
	// a wake or a block only on a found semaphore
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (woken_valid || caller_blocked) |-> ok)
		else $error("wake without ok");
	// no item taken in the cycle after one was taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");
endmodule

bind counting_semaphore_table_top cst_port_checker u_cst_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .ok(ok),
	.caller_blocked(caller_blocked), .woken_valid(woken_valid),
	.new_id(new_id), .woken_pid(woken_pid), .last(last)
);
`default_nettype wire

// ===== bench/cst_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cst_checker: semaphore table scoreboard
// Watches both channels, predicts every result of each accepted item with a
// behavioural copy of the semaphore table and compares field by field.
// ---------------------------------------------------------------------------
module cst_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [31:0] sem_id,
	input  wire logic [31:0] operand_value,
	input  wire logic [4:0]  caller_pid,
	input  wire logic        random_enable,
	input  wire logic [63:0] entropy,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        ok,
	input  wire logic        caller_blocked,
	input  wire logic [31:0] new_id,
	input  wire logic [31:0] count_read,
	input  wire logic        woken_valid,
	input  wire logic [4:0]  woken_pid,
	input  wire logic        last,
	output int               fail_count,
	output int               pending
);
	localparam int NumSem  = cst_pkg::NumSem;
	localparam int NumProc = cst_pkg::NumProc;

	// shadow copy of the table
	bit              sh_used [NumSem];
	bit [31:0]       sh_id [NumSem];
	bit signed [31:0] sh_count [NumSem];
	bit [15:0]       sh_refs [NumSem];
	bit              sh_rnd [NumSem];
	int              sh_head [NumSem];
	int              sh_tail [NumSem];
	int              sh_next [NumProc];
	bit              sh_queued [NumProc];
	bit [31:0]       sh_idctr;
	bit [63:0]       sh_lcg;

	cst_pkg::result_t expected_results[$];

	function automatic cst_pkg::result_t mk(bit okv, bit blk, bit [31:0] nid, bit [31:0] cnt,
			bit wv, bit [4:0] wp, bit lst);
		cst_pkg::result_t r;
		r.ok = okv;
		r.caller_blocked = blk;
		r.new_id = nid;
		r.count_read = cnt;
		r.woken_valid = wv;
		r.woken_pid = wv ? wp : 5'd0;
		r.last = lst;
		return r;
	endfunction

	function automatic int pop_head(int s);
		int h;
		h = sh_head[s];
		if (h >= NumProc)
			return NumProc;
		sh_head[s] = sh_next[h];
		if (sh_head[s] >= NumProc)
			sh_tail[s] = NumProc;
		sh_queued[h] = 0;
		return h;
	endfunction

	// choose a waiter: FIFO head, or an LCG pick in random mode when several are queued
	function automatic int pick_waiter(int s, bit [63:0] ent);
		int p, prv, n, tgt;
		bit [63:0] seed;
		if (!sh_rnd[s])
			return pop_head(s);
		n = 0;
		p = sh_head[s];
		while (p < NumProc && n < NumProc) begin
			n++;
			p = sh_next[p];
		end
		if (n <= 1)
			return pop_head(s);
		seed = ent ^ 64'(s) ^ sh_lcg;
		seed = seed * cst_pkg::LCG_MUL + cst_pkg::LCG_INC;
		sh_lcg = seed;
		tgt = int'((seed >> 16) % 64'(n));
		prv = NumProc;
		p = sh_head[s];
		for (int i = 0; i < tgt; i++) begin
			prv = p;
			p = sh_next[p];
		end
		if (prv < NumProc)
			sh_next[prv] = sh_next[p];
		else
			sh_head[s] = sh_next[p];
		if (p == sh_tail[s])
			sh_tail[s] = prv;
		sh_queued[p] = 0;
		return p;
	endfunction

	task automatic table_reset();
		for (int i = 0; i < NumSem; i++) begin
			sh_used[i] = 0;
			sh_id[i] = 0;
			sh_count[i] = 0;
			sh_refs[i] = 0;
			sh_rnd[i] = 0;
			sh_head[i] = NumProc;
			sh_tail[i] = NumProc;
		end
		for (int i = 0; i < NumProc; i++) begin
			sh_next[i] = 0;
			sh_queued[i] = 0;
		end
		sh_idctr = 1;
		sh_lcg = cst_pkg::LCG_INIT;
	endtask

	// apply one operation to the shadow table and queue its results
	task automatic predict_op(bit [2:0] k, bit [31:0] id, bit signed [31:0] val,
			bit [4:0] pid, bit rnd, bit [63:0] ent);
		int s, n, w, p;
		s = -1;
		if (k == cst_pkg::OP_ALLOC) begin
			for (int i = 0; i < NumSem; i++)
				if (!sh_used[i] && s < 0)
					s = i;
			if (s < 0) begin
				expected_results.push_back(mk(0, 0, 0, 0, 0, 0, 1));
				return;
			end
			sh_used[s] = 1;
			sh_id[s] = sh_idctr;
			sh_count[s] = val;
			sh_refs[s] = 1;
			sh_rnd[s] = 0;
			sh_head[s] = NumProc;
			sh_tail[s] = NumProc;
			expected_results.push_back(mk(1, 0, sh_idctr, 0, 0, 0, 1));
			sh_idctr++;
			if (sh_idctr == 0)
				sh_idctr = 1;
			return;
		end
		if (id != 0)
			for (int i = NumSem - 1; i >= 0; i--)
				if (sh_used[i] && sh_id[i] == id)
					s = i;
		if (s < 0) begin
			expected_results.push_back(mk(0, 0, 0, 0, 0, 0, 1));
			return;
		end
		case (k)
			cst_pkg::OP_OPEN: begin
				if (sh_refs[s] != 16'hFFFF)
					sh_refs[s]++;
			end
			cst_pkg::OP_CLOSE: begin
				if (sh_refs[s] > 0)
					sh_refs[s]--;
				if (sh_refs[s] == 0) begin
					p = sh_head[s];
					n = 0;
					while (p < NumProc && n < NumProc) begin
						sh_queued[p] = 0;
						p = sh_next[p];
						n++;
					end
					sh_used[s] = 0;
					sh_head[s] = NumProc;
					sh_tail[s] = NumProc;
				end
			end
			cst_pkg::OP_WAIT: begin
				if (sh_queued[pid]) begin
					expected_results.push_back(mk(0, 0, 0, 0, 0, 0, 1));
					return;
				end
				if (sh_count[s] > 0)
					sh_count[s]--;
				else begin
					sh_next[pid] = NumProc;
					if (sh_head[s] >= NumProc)
						sh_head[s] = pid;
					else
						sh_next[sh_tail[s]] = pid;
					sh_tail[s] = pid;
					sh_queued[pid] = 1;
					expected_results.push_back(mk(1, 1, 0, 0, 0, 0, 1));
					return;
				end
			end
			cst_pkg::OP_SIGNAL: begin
				w = pick_waiter(s, ent);
				if (w < NumProc) begin
					expected_results.push_back(mk(1, 0, 0, 0, 1, 5'(w), 1));
					return;
				end
				if (sh_count[s] != 32'sh7FFFFFFF)
					sh_count[s]++;
			end
			cst_pkg::OP_SET: begin
				if (val < 0) begin
					expected_results.push_back(mk(0, 0, 0, 0, 0, 0, 1));
					return;
				end
				n = 0;
				while (n < val && n < NumProc) begin
					w = pick_waiter(s, ent);
					if (w >= NumProc)
						break;
					expected_results.push_back(mk(1, 0, 0, 0, 1, 5'(w), 0));
					n++;
				end
				sh_count[s] = val - n;
				if (n == 0)
					expected_results.push_back(mk(1, 0, 0, 0, 0, 0, 1));
				else
					expected_results[$].last = 1;
				return;
			end
			cst_pkg::OP_GET: begin
				expected_results.push_back(mk(1, 0, 0, sh_count[s], 0, 0, 1));
				return;
			end
			default: sh_rnd[s] = rnd;
		endcase
		expected_results.push_back(mk(1, 0, 0, 0, 0, 0, 1));
	endtask

	// one note per differing field
	task automatic compare_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		table_reset();
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		cst_pkg::result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					compare_field("ok", e.ok, ok);
					compare_field("caller_blocked", e.caller_blocked, caller_blocked);
					compare_field("new_id", e.new_id, new_id);
					compare_field("count_read", e.count_read, count_read);
					compare_field("woken_valid", e.woken_valid, woken_valid);
					compare_field("woken_pid", e.woken_pid, woken_pid);
					compare_field("last", e.last, last);
				end
			end
			if (in_valid && !in_stall)
				predict_op(kind, sem_id, operand_value, caller_pid, random_enable,
					entropy);
			pending = expected_results.size();
		end
	end
endmodule
`default_nettype wire

// ===== bench/tb_counting_semaphore_table_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb_counting_semaphore_table_top: semaphore table testbench
// Directed and random operation streams with random gaps on both channels;
// a checker beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_counting_semaphore_table_top;
	localparam int CycleLimit = 12000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  kind = cst_pkg::OP_ALLOC;
	logic [31:0] sem_id = 0;
	logic signed [31:0] operand_value = 0;
	logic [4:0]  caller_pid = 0;
	logic        random_enable = 0;
	logic [63:0] entropy = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        ok, caller_blocked, woken_valid, last;
	logic [31:0] new_id;
	logic signed [31:0] count_read;
	logic [4:0]  woken_pid;
	int          fail_count, pending;
	int          cycle_count = 0;
	bit [31:0]   live_ids[$];

	always #4 clk = ~clk;

	counting_semaphore_table_top dut (.*);

	cst_checker checker_i (.*);

	// run-time limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 0;
	endfunction

	// receiver stall pattern
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1;
				repeat (g) @(negedge clk);
			end
			out_stall <= 0;
		end
	end

	// present one item and hold it until accepted; valid stays high into a
	// back-to-back item and drops only for a gap
	task automatic send_op(bit [2:0] k, bit [31:0] id, bit [31:0] val,
			bit [4:0] pid, bit rnd, bit [63:0] ent);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		kind <= k;
		sem_id <= id;
		operand_value <= val;
		caller_pid <= pid;
		random_enable <= rnd;
		entropy <= ent;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	// id that the next do_alloc records as live; it counts do_alloc calls
	bit [31:0] next_id = 1;

	function automatic bit [31:0] pick_id();
		if (live_ids.size() == 0 || $urandom_range(0, 19) == 0)
			return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom();
		return live_ids[$urandom_range(0, live_ids.size() - 1)];
	endfunction

	task automatic do_alloc(bit [31:0] val);
		send_op(cst_pkg::OP_ALLOC, $urandom(), val, 5'($urandom()), 1'($urandom()),
			{$urandom(), $urandom()});
		live_ids.push_back(next_id);
		next_id++;
	endtask

	initial begin
		bit [31:0] id;
		int op;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: extremes, every operation, unknown ids, duplicates
		do_alloc(32'sh7FFFFFFF);
		do_alloc(32'sh80000000);
		do_alloc(0);
		send_op(cst_pkg::OP_SIGNAL, 1, 0, 0, 0, 0);
		send_op(cst_pkg::OP_GET, 1, 0, 0, 0, 0);
		send_op(cst_pkg::OP_GET, 2, 0, 0, 0, 0);
		send_op(cst_pkg::OP_GET, 0, 0, 0, 0, 0);
		send_op(cst_pkg::OP_GET, 32'hFFFFFFFF, 0, 0, 0, 0);
		send_op(cst_pkg::OP_WAIT, 3, 0, 5'd31, 0, 0);
		send_op(cst_pkg::OP_WAIT, 3, 0, 5'd0, 0, 0);
		send_op(cst_pkg::OP_WAIT, 3, 0, 5'd31, 0, 0);
		send_op(cst_pkg::OP_MODE, 3, 0, 0, 1, 0);
		send_op(cst_pkg::OP_WAIT, 3, 0, 5'd7, 1, 0);
		send_op(cst_pkg::OP_SIGNAL, 3, 0, 0, 0, 64'hFFFFFFFFFFFFFFFF);
		send_op(cst_pkg::OP_SET, 3, 32'hFFFFFFFF, 0, 0, 0);
		send_op(cst_pkg::OP_SET, 3, 5, 0, 0, 64'h0123456789ABCDEF);
		send_op(cst_pkg::OP_OPEN, 3, 0, 0, 0, 0);
		send_op(cst_pkg::OP_CLOSE, 3, 0, 0, 0, 0);
		send_op(cst_pkg::OP_WAIT, 3, 0, 5'd9, 0, 0);
		send_op(cst_pkg::OP_CLOSE, 3, 0, 0, 0, 0);
		send_op(cst_pkg::OP_GET, 3, 0, 0, 0, 0);
		void'(live_ids.pop_back());
		// pause until the table has answered everything
		drain();

		// random part: most items aimed at live semaphores
		for (int n = 0; n < 400; n++) begin
			op = $urandom_range(0, 99);
			id = pick_id();
			if (op < 8 || live_ids.size() < 2) begin
				if (live_ids.size() < 60)
					do_alloc($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 2));
				else
					send_op(cst_pkg::OP_ALLOC, 0, 0, 0, 0, 0);
			end else if (op < 38)
				send_op(cst_pkg::OP_WAIT, id, 0, 5'($urandom()), 0,
					{$urandom(), $urandom()});
			else if (op < 55)
				send_op(cst_pkg::OP_SIGNAL, id, 0, 0, 0, {$urandom(), $urandom()});
			else if (op < 65)
				send_op(cst_pkg::OP_SET, id, $urandom_range(0, 9) == 0 ? $urandom()
					: $urandom_range(0, 6), 0, 0, {$urandom(), $urandom()});
			else if (op < 75)
				send_op(cst_pkg::OP_GET, id, $urandom(), 5'($urandom()), 1'($urandom()), 0);
			else if (op < 85)
				send_op(cst_pkg::OP_MODE, id, 0, 0, 1'($urandom()), 0);
			else if (op < 92)
				send_op(cst_pkg::OP_OPEN, id, 0, 0, 0, 0);
			else
				send_op(cst_pkg::OP_CLOSE, id, 0, 0, 0, 0);
			// after some closes, drain and read the closed id back
			if (op >= 92 && $urandom_range(0, 1) == 0) begin
				drain();
				send_op(cst_pkg::OP_GET, id, 0, 0, 0, 0);
			end
		end

		drain();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
